// File: rtl/core/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and codes of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // width of the entry number, size and counter fields
    localparam int FIELD_W = 14;

    // reset value of the size register and the free counter
    localparam logic [FIELD_W-1:0] REG_RESET = 14'd8192;

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_FREE = 8'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } state_t;

endpackage

// File: rtl/core/bffa_ffz.sv
// ----------------------------------------------------------------------------
// bffa_ffz
// Find-first-zero unit: lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bffa_ffz import bffa_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         word_bits,
    output logic                         found,
    output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

    localparam int WSH = $clog2(WORD_BITS);

    // priority pick, lowest clear bit wins
    always_comb begin
        found   = 1'b0;
        bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word_bits[b]) begin
                found   = 1'b1;
                bit_idx = WSH'(b);
            end
        end
    end

endmodule

// File: rtl/core/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit bitmap allocator: one used bit per entry in a word memory, a
// free counter, allocate of the lowest free entry and free by number.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_       in         request: tuser command, tdata entry number
//  m_       out        result: tuser status, tdata granted number and count
//  cfg_     in         register write: index and data
//
//  allocate reads words from word 0 until a free entry or the last word
//  (1 to WORD_COUNT words scanned); one memory word is read and tested per cycle
//  free reads the entry's word, then does one read-modify-write
//  after reset a clearing pass zeroes the memory word by word,
//  no request is accepted meanwhile; register writes are taken at all times
//  a request is accepted while the previous result still waits; the block
//  holds its last step while the result register is occupied
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator import bffa_pkg::*; #(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [13:0] entry_number, [15:14] zero
    input  logic [0:0]             s_tuser,   // [0] command
    // result
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [13:0] granted_number,
                                              // [27:14] free_count, [31:28] zero
    output logic [1:0]             m_tuser,   // [1:0] status
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data
);

    localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WSH        = $clog2(WORD_BITS);

    // state and registers
    state_t                 state_reg, state_next;
    logic [FIELD_W-1:0]     map_size_reg, map_size_next;
    logic [FIELD_W-1:0]     free_cnt_reg, free_cnt_next;
    logic [FIELD_W-1:0]     num_reg, num_next;
    logic [ADDR_W-1:0]      chk_word_reg, chk_word_next;
    logic [ADDR_W-1:0]      last_word_reg, last_word_next;
    logic [WORD_BITS-1:0]   tail_mask_reg, tail_mask_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [FIELD_W-1:0]     out_grant_reg, out_grant_next;
    logic [FIELD_W-1:0]     out_count_reg, out_count_next;

    // bitmap memory
    logic [WORD_BITS-1:0]   mem [WORD_COUNT];
    logic [WORD_BITS-1:0]   rdata_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0]   wr_data;

    // helpers
    logic [FIELD_W-1:0]     eff_size;
    logic                   out_free;
    logic [31:0]            in_idx;
    logic [31:0]            num_idx;
    logic [31:0]            last_idx;
    logic [31:0]            grant_sum;
    logic [WSH-1:0]         tail_rem;
    logic [WORD_BITS-1:0]   scan_word;
    logic                   ffz_found;
    logic [WSH-1:0]         ffz_idx;
    logic                   at_last;
    logic                   range_bad;

    // effective size, clamped to the map
    always_comb begin
        if (32'(map_size_reg) > 32'(MAP_BITS)) begin
            eff_size = FIELD_W'(MAP_BITS);
        end else begin
            eff_size = map_size_reg;
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign in_idx    = 32'(s_tdata[FIELD_W-1:0]) - 32'd1;
    assign num_idx   = 32'(num_reg) - 32'd1;
    assign last_idx  = (32'(eff_size) - 32'd1) >> WSH;
    assign tail_rem  = eff_size[WSH-1:0];
    assign at_last   = (chk_word_reg == last_word_reg);
    assign range_bad = (num_reg == '0) || (num_reg > eff_size);

    // bits past the map size read as used
    assign scan_word = rdata_reg | ~(at_last ? tail_mask_reg : {WORD_BITS{1'b1}});

    bffa_ffz #(
        .WORD_BITS (WORD_BITS)
    ) u_ffz (
        .word_bits (scan_word),
        .found     (ffz_found),
        .bit_idx   (ffz_idx)
    );

    assign grant_sum = (32'(chk_word_reg) << WSH) + 32'(ffz_idx) + 32'd1;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        map_size_next   = map_size_reg;
        free_cnt_next   = free_cnt_reg;
        num_next        = num_reg;
        chk_word_next   = chk_word_reg;
        last_word_next  = last_word_reg;
        tail_mask_next  = tail_mask_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_count_next  = out_count_reg;
        s_tready        = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(WORD_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tuser[0] == CMD_FREE) begin
                    rd_addr = in_idx[WSH +: ADDR_W];
                end
                if (s_tvalid) begin
                    num_next = s_tdata[FIELD_W-1:0];
                    if (s_tuser[0] == CMD_FREE) begin
                        state_next = ST_FREE;
                    end else begin
                        state_next    = ST_SCAN;
                        chk_word_next = '0;
                        // last word and its valid bits
                        if (eff_size == '0) begin
                            last_word_next = '0;
                            tail_mask_next = '0;
                        end else begin
                            last_word_next = last_idx[ADDR_W-1:0];
                            for (int b = 0; b < WORD_BITS; b++) begin
                                tail_mask_next[b] = (tail_rem == '0) ||
                                                    (32'(b) < 32'(tail_rem));
                            end
                        end
                    end
                end
            end

            ST_SCAN: begin
                if (ffz_found || at_last) begin
                    rd_addr = chk_word_reg;
                    if (out_free) begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                        if (ffz_found) begin
                            wr_en   = 1'b1;
                            wr_addr = chk_word_reg;
                            wr_data = rdata_reg | (WORD_BITS'(1) << ffz_idx);
                            if (free_cnt_reg != '0) begin
                                free_cnt_next = free_cnt_reg - 1'b1;
                            end
                            out_status_next = STATUS_DONE;
                            out_grant_next  = grant_sum[FIELD_W-1:0];
                        end else begin
                            out_status_next = STATUS_FULL;
                            out_grant_next  = '0;
                        end
                        out_count_next = free_cnt_next;
                    end
                end else begin
                    rd_addr       = chk_word_reg + 1'b1;
                    chk_word_next = chk_word_reg + 1'b1;
                end
            end

            ST_FREE: begin
                rd_addr = num_idx[WSH +: ADDR_W];
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_grant_next = '0;
                    if (range_bad) begin
                        out_status_next = STATUS_RANGE;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = num_idx[WSH +: ADDR_W];
                        wr_data = rdata_reg & ~(WORD_BITS'(1) << num_idx[WSH-1:0]);
                        if (free_cnt_reg < eff_size) begin
                            free_cnt_next = free_cnt_reg + 1'b1;
                        end
                        out_status_next = STATUS_DONE;
                    end
                    out_count_next = free_cnt_next;
                end
            end

            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // register writes, to be issued only while no request is in flight; the block does not enforce this
        if (cfg_valid) begin
            if (cfg_index == CFG_MAP_SIZE) begin
                map_size_next = cfg_data;
            end else if (cfg_index == CFG_START_FREE) begin
                free_cnt_next = cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            map_size_reg  <= REG_RESET;
            free_cnt_reg  <= REG_RESET;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            map_size_reg  <= map_size_next;
            free_cnt_reg  <= free_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        num_reg        <= num_next;
        chk_word_reg   <= chk_word_next;
        last_word_reg  <= last_word_next;
        tail_mask_reg  <= tail_mask_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
        out_count_reg  <= out_count_next;
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_grant_reg};

    // scan never runs past the last word of the map
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> chk_word_reg <= last_word_reg)
        else $error("scan past last word");

    // a grant only comes with a done status
    a_grant_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[FIELD_W-1:0] != '0) |-> m_tuser == STATUS_DONE)
        else $error("grant with failing status");

    // the bitmap is written only by the clearing pass or a finishing request
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_CLEAR) ||
                  ((state_reg != ST_IDLE) && (state_next == ST_IDLE)))
        else $error("bitmap write outside a finishing step");

    // no request is accepted before the clearing pass has ended
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) == ST_CLEAR && state_reg == ST_CLEAR |-> !s_tready)
        else $error("request accepted during clearing");

    // a new result is only loaded into a free output register
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_grant_reg))
        else $error("result overwritten while waiting");

endmodule

// File: verif/bitmap_first_free_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_tb
// Self-checking bench for the first-fit bitmap allocator. A scoreboard
// keeps its own copy of the used bitmap, the size register and the free
// counter, predicts status, granted number and count for every accepted
// request, and checks each result word in order. Directed requests hit the
// corner cases first. Random phases follow, each under its own register
// setting, most with random idling on both sides, and one long result hold-off.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int ENTRY_COUNT      = 8192;
    localparam int FIELD_MAX        = (1 << FIELD_W) - 1;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int RX_HOLD_CYCLES   = 1500;
    localparam int PHASE_COUNT      = 6;

    // index past the two registers, written to show it is ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = CFG_START_FREE + 8'd1;

    // idling modes
    localparam int IDLE_RX_HEAVY = 0;
    localparam int IDLE_TX_HEAVY = 1;
    localparam int IDLE_NONE     = 2;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] granted;
        logic [FIELD_W-1:0] count;
    } alloc_result_t;

    // bitmap and counter predictor with in-order result check
    class alloc_scoreboard;
        bit                 used_map [ENTRY_COUNT];
        logic [FIELD_W-1:0] size_reg;
        logic [FIELD_W-1:0] free_cnt;
        alloc_result_t      expected_q [$];
        int                 errors;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b0;
            size_reg = REG_RESET;
            free_cnt = REG_RESET;
            errors   = 0;
        endfunction

        // entries actually searched, clamped to the bitmap depth
        function int span();
            return (int'(size_reg) > ENTRY_COUNT) ? ENTRY_COUNT : int'(size_reg);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [FIELD_W-1:0] val);
            if (idx == CFG_MAP_SIZE) begin
                size_reg = val;
            end else if (idx == CFG_START_FREE) begin
                free_cnt = val;
            end
        endfunction

        function void note_request(logic cmd, logic [FIELD_W-1:0] num);
            int            limit;
            int            slot;
            alloc_result_t res;
            limit       = span();
            slot        = -1;
            res.status  = STATUS_DONE;
            res.granted = '0;
            if (cmd == CMD_ALLOC) begin
                // lowest clear bit below the size
                for (int i = 0; i < limit; i++) begin
                    if (!used_map[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0) begin
                    used_map[slot] = 1'b1;
                    if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
                    res.granted = FIELD_W'(slot + 1);
                end else begin
                    res.status = STATUS_FULL;
                end
            end else begin
                if (num == 0 || int'(num) > limit) begin
                    res.status = STATUS_RANGE;
                end else begin
                    used_map[int'(num) - 1] = 1'b0;
                    // saturates at the size, left alone when loaded above it
                    if (int'(free_cnt) < limit) free_cnt = free_cnt + 1'b1;
                end
            end
            res.count = free_cnt;
            expected_q.push_back(res);
        endfunction

        function void field_check(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t result %s mismatch: expected %0d actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] data);
            alloc_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result word: expected none actual status %0d data %h",
                         $time, st, data);
                return;
            end
            want = expected_q.pop_front();
            field_check("status", want.status, st);
            field_check("granted_number", want.granted, data[13:0]);
            field_check("free_count", want.count, data[27:14]);
            field_check("padding", 0, data[31:28]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // [13:0] entry_number, [15:14] zero
    logic [0:0]             s_tuser   = '0;   // [0] command
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;          // [13:0] granted_number, [27:14] free_count
    logic [1:0]             m_tuser;          // [1:0] status
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]     cfg_data  = '0;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold     = 1'b0;
    bit  rx_hold_go  = 1'b0;
    int  cycle_count;

    alloc_scoreboard alloc_sb = new();

    bitmap_first_free_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #6 aclk = ~aclk;

    // idling mode, changed away from the rising edge
    task automatic set_idling(input int mode);
        @(negedge aclk);
        case (mode)
            IDLE_RX_HEAVY: begin
                tx_idle_pct = 12;
                rx_idle_pct = 86;
            end
            IDLE_TX_HEAVY: begin
                tx_idle_pct = 86;
                rx_idle_pct = 12;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
        @(posedge aclk);
    endtask

    // register write; valid is dropped after the handshake
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [FIELD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        alloc_sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one request word; valid stays high for the caller to reuse or drop
    task automatic push_request(input logic cmd, input logic [FIELD_W-1:0] num);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, num};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        alloc_sb.note_request(cmd, num);
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (alloc_sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly allocations and frees of live low entries, some range noise
    task automatic random_request();
        int                 pick;
        int                 limit;
        logic [FIELD_W-1:0] num;
        limit = alloc_sb.span();
        pick  = $urandom_range(0, 99);
        if (pick < 55 || limit == 0) begin
            num = FIELD_W'($urandom_range(0, FIELD_MAX));
            push_request(pick < 55 ? CMD_ALLOC : CMD_FREE, num);
        end else if (pick < 80) begin
            num = FIELD_W'($urandom_range(1, limit < 128 ? limit : 128));
            push_request(CMD_FREE, num);
        end else if (pick < 90) begin
            num = FIELD_W'($urandom_range(1, limit));
            push_request(CMD_FREE, num);
        end else begin
            num = FIELD_W'($urandom_range(0, FIELD_MAX));
            push_request(CMD_FREE, num);
        end
    endtask

    // main stimulus
    initial begin
        int phase_size  [PHASE_COUNT] = '{8192, 40, 16383, 300, 1, 100};
        int phase_start [PHASE_COUNT] = '{8192, 40, 0, 16383, 1, 57};
        int phase_mode  [PHASE_COUNT] = '{IDLE_RX_HEAVY, IDLE_RX_HEAVY, IDLE_TX_HEAVY,
                                          IDLE_TX_HEAVY, IDLE_NONE, IDLE_NONE};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(IDLE_RX_HEAVY);

        // reset setting: first fit, reuse, range rejects, saturation
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_FREE, 14'd2);
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_FREE, 14'd2);
        push_request(CMD_FREE, 14'd2);
        push_request(CMD_FREE, 14'd0);
        push_request(CMD_FREE, 14'd8193);
        push_request(CMD_FREE, 14'(FIELD_MAX));
        push_request(CMD_FREE, 14'd8192);
        push_request(CMD_FREE, 14'd8192);
        push_request(CMD_ALLOC, 14'(FIELD_MAX));
        settle();

        // zero size: nothing to allocate, every free out of range
        cfg_write(CFG_MAP_SIZE, 14'd0);
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_FREE, 14'd1);
        settle();

        // counter at zero while an entry is still free
        cfg_write(CFG_MAP_SIZE, 14'd3);
        cfg_write(CFG_START_FREE, 14'd0);
        push_request(CMD_FREE, 14'd3);
        settle();
        cfg_write(CFG_START_FREE, 14'd0);
        push_request(CMD_ALLOC, 14'd0);
        push_request(CMD_ALLOC, 14'd0);
        settle();

        // loaded counter above the size stays put on free
        cfg_write(CFG_START_FREE, 14'd100);
        push_request(CMD_FREE, 14'd1);
        settle();

        // size above the bitmap depth is clamped; unknown index ignored
        cfg_write(CFG_MAP_SIZE, 14'(FIELD_MAX));
        cfg_write(CFG_UNUSED, 14'd0);
        push_request(CMD_FREE, 14'd8192);
        push_request(CMD_FREE, 14'd8193);
        push_request(CMD_ALLOC, 14'd0);
        settle();

        // random phases, one register setting each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_idling(phase_mode[p]);
            cfg_write(CFG_MAP_SIZE, 14'(phase_size[p]));
            cfg_write(CFG_START_FREE, 14'(phase_start[p]));
            if (p == PHASE_COUNT - 1) rx_hold_go = 1'b1;
            repeat (RANDOM_PER_PHASE) random_request();
            settle();
        end

        // drain tail: allow a full-depth scan for any stray word
        repeat (300) @(posedge aclk);
        if (alloc_sb.errors == 0 && alloc_sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // long result hold-off so the block backs up into its input
    initial begin
        wait (rx_hold_go);
        @(negedge aclk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        @(negedge aclk);
        rx_hold = 1'b0;
    end

    // result side: random ready, word taken when both high at the edge
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) alloc_sb.check_result(m_tuser, m_tdata);
            @(posedge aclk);
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // run limit
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("%0t run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
